[hdl/spm_pkg.sv]
// ----------------------------------------------------------------------------
// spm_pkg
// types, register map and reset values shared by the sync period monitor
// ----------------------------------------------------------------------------
`default_nettype none

package spm_pkg;

  localparam int unsigned NOW_W    = 64;
  localparam int unsigned PERIOD_W = 32;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned APB_AW   = 4;
  localparam int unsigned APB_DW   = 32;

  localparam logic [CFG_W-1:0] MATCH_WINDOW_RST   = 16'd10;
  localparam logic [CFG_W-1:0] PERIOD_MIN_RST     = 16'd400;
  localparam logic [CFG_W-1:0] PERIOD_MAX_RST     = 16'd65000;
  localparam logic [CFG_W-1:0] TIMEOUT_MARGIN_RST = 16'd100;

  typedef enum logic [1:0] {
    REG_MATCH_WINDOW   = 2'd0,
    REG_PERIOD_MIN     = 2'd1,
    REG_PERIOD_MAX     = 2'd2,
    REG_TIMEOUT_MARGIN = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    PH_LEARN   = 2'd0,
    PH_ACTIVE  = 2'd1,
    PH_TIMEOUT = 2'd2
  } phase_t;

  typedef enum logic {
    REQ_SYNC  = 1'b0,
    REQ_CHECK = 1'b1
  } req_t;

  typedef struct packed {
    logic [CFG_W-1:0] match_window;
    logic [CFG_W-1:0] period_min;
    logic [CFG_W-1:0] period_max;
    logic [CFG_W-1:0] timeout_margin;
  } cfg_t;

  typedef struct packed {
    phase_t              phase;
    logic [NOW_W-1:0]    last_stamp;
    logic [PERIOD_W-1:0] period_est;
  } mon_state_t;

  typedef struct packed {
    logic                step_ok;
    logic                timeout_seen;
    logic [1:0]          mon_state;
    logic [PERIOD_W-1:0] learned_period;
  } result_t;

endpackage

`default_nettype wire

[hdl/spm_regs.sv]
// ----------------------------------------------------------------------------
// spm_regs
// apb configuration registers of the sync period monitor
// ----------------------------------------------------------------------------
`default_nettype none

module spm_regs
  import spm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_MATCH_WINDOW:   cfg_nxt.match_window   = pwdata[CFG_W-1:0];
        REG_PERIOD_MIN:     cfg_nxt.period_min     = pwdata[CFG_W-1:0];
        REG_PERIOD_MAX:     cfg_nxt.period_max     = pwdata[CFG_W-1:0];
        REG_TIMEOUT_MARGIN: cfg_nxt.timeout_margin = pwdata[CFG_W-1:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.match_window   <= MATCH_WINDOW_RST;
      cfg_r.period_min     <= PERIOD_MIN_RST;
      cfg_r.period_max     <= PERIOD_MAX_RST;
      cfg_r.timeout_margin <= TIMEOUT_MARGIN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    unique case (idx)
      REG_MATCH_WINDOW:   prdata = {{(APB_DW-CFG_W){1'b0}}, cfg_r.match_window};
      REG_PERIOD_MIN:     prdata = {{(APB_DW-CFG_W){1'b0}}, cfg_r.period_min};
      REG_PERIOD_MAX:     prdata = {{(APB_DW-CFG_W){1'b0}}, cfg_r.period_max};
      REG_TIMEOUT_MARGIN: prdata = {{(APB_DW-CFG_W){1'b0}}, cfg_r.timeout_margin};
      default:            prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

[hdl/spm_step.sv]
// ----------------------------------------------------------------------------
// spm_step
// next-state and result logic for one sync or check beat
// ----------------------------------------------------------------------------
`default_nettype none

module spm_step
  import spm_pkg::*;
(
  input  wire cfg_t              cfg,
  input  wire mon_state_t        cur,
  input  wire logic              req_type,
  input  wire logic [NOW_W-1:0]  now_us,
  output mon_state_t             nxt,
  output result_t                res
);

  logic [PERIOD_W-1:0] period;
  logic [PERIOD_W-1:0] diff;
  logic [PERIOD_W-1:0] sum;
  logic [PERIOD_W-1:0] avg;
  logic [NOW_W-1:0]    limit;
  logic                match;
  logic                in_range;
  logic                no_stamp;
  logic                ok;
  logic                tmo;

  assign period   = now_us[PERIOD_W-1:0] - cur.last_stamp[PERIOD_W-1:0];
  assign diff     = period - cur.period_est;
  assign sum      = cur.period_est + period;
  assign avg      = {1'b0, sum[PERIOD_W-1:1]};
  assign match    = diff < {{(PERIOD_W-CFG_W){1'b0}}, cfg.match_window};
  assign in_range = (avg >= {{(PERIOD_W-CFG_W){1'b0}}, cfg.period_min}) &&
                    (avg <= {{(PERIOD_W-CFG_W){1'b0}}, cfg.period_max});
  assign no_stamp = (cur.last_stamp == '0);
  assign limit    = cur.last_stamp
                  + {{(NOW_W-PERIOD_W){1'b0}}, cur.period_est}
                  + {{(NOW_W-CFG_W){1'b0}}, cfg.timeout_margin};

  // next state
  always_comb begin
    nxt = cur;
    if (req_t'(req_type) == REQ_SYNC) begin
      unique case (cur.phase)
        PH_LEARN: begin
          nxt.last_stamp = now_us;
          if (!no_stamp) begin
            if (match) begin
              nxt.period_est = avg;
              if (in_range) begin
                nxt.phase = PH_ACTIVE;
              end
            end else begin
              nxt.period_est = period;
            end
          end
        end
        PH_ACTIVE: begin
          nxt.last_stamp = now_us;
        end
        default: begin
          nxt.phase      = PH_LEARN;
          nxt.last_stamp = '0;
          nxt.period_est = '0;
        end
      endcase
    end else if (cur.phase == PH_ACTIVE && now_us > limit) begin
      nxt.phase = PH_TIMEOUT;
    end
  end

  // outputs
  always_comb begin
    ok  = 1'b0;
    tmo = 1'b0;
    if (req_t'(req_type) == REQ_SYNC) begin
      ok = !(cur.phase == PH_LEARN && !no_stamp && match && !in_range);
    end else begin
      tmo = (cur.phase == PH_ACTIVE) && (now_us > limit);
    end
    res.step_ok        = ok;
    res.timeout_seen   = tmo;
    res.mon_state      = nxt.phase;
    res.learned_period = nxt.period_est;
  end

endmodule

`default_nettype wire

[hdl/sync_period_monitor_top.sv]
// ----------------------------------------------------------------------------
// sync_period_monitor_top
// learns the period of a sync event and flags a missing sync on request
// ----------------------------------------------------------------------------
//  channel  direction  handshake             payload
//  in       input      in_valid / in_ready   in_req_type, in_now_us
//  out      output     out_valid / out_ready out_step_ok, out_timeout_seen,
//                                            out_mon_state, out_learned_period_us
//  apb      input      psel/penable/pready   paddr, pwdata, prdata
//
//  one beat per cycle while the result register is not stalled; a beat goes
//  into the input register, then the state update and result register load
//  happen together, so the result beat is offered from the result register
//  the throughput limit is the loop through the period state register
//  a stalled result register holds the input register, which then drops in_ready
//  synchronous reset puts the monitor into learning with no stamp
// ----------------------------------------------------------------------------
`default_nettype none

module sync_period_monitor_top
  import spm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_req_type,
  input  wire logic [NOW_W-1:0]  in_now_us,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_step_ok,
  output logic                   out_timeout_seen,
  output logic      [1:0]        out_mon_state,
  output logic      [PERIOD_W-1:0] out_learned_period_us,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready
);

  cfg_t             cfg;
  logic             s1_valid_r;
  logic             s1_req_r;
  logic [NOW_W-1:0] s1_now_r;
  mon_state_t       st_r;
  mon_state_t       st_nxt;
  result_t          res;
  result_t          out_r;
  logic             out_valid_r;
  logic             out_load;
  logic             step;

  spm_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  spm_step u_step (
    .cfg      (cfg),
    .cur      (st_r),
    .req_type (s1_req_r),
    .now_us   (s1_now_r),
    .nxt      (st_nxt),
    .res      (res)
  );

  assign out_load = !out_valid_r || out_ready;
  assign step     = s1_valid_r && out_load;
  assign in_ready = !s1_valid_r || out_load;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_req_r <= in_req_type;
      s1_now_r <= in_now_us;
    end
  end

  // monitor state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase      <= PH_LEARN;
      st_r.last_stamp <= '0;
      st_r.period_est <= '0;
    end else if (step) begin
      st_r <= st_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_r <= res;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_step_ok           = out_r.step_ok;
  assign out_timeout_seen      = out_r.timeout_seen;
  assign out_mon_state         = out_r.mon_state;
  assign out_learned_period_us = out_r.learned_period;

endmodule

`default_nettype wire

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the sync period monitor: a queue-fed driver offers
// sync and timeout-check beats, a tracking model predicts each result at
// acceptance, and a monitor compares every result beat field by field while
// both sides idle at random and the register settings move between extremes
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import spm_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    req_t             req;
    logic [NOW_W-1:0] now;
  } sync_req_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_req_type = 1'b0;
  logic [NOW_W-1:0]      in_now_us = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_step_ok;
  logic                  out_timeout_seen;
  logic [1:0]            out_mon_state;
  logic [PERIOD_W-1:0]   out_learned_period_us;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_AW-1:0]     paddr = '0;
  logic [APB_DW-1:0]     pwdata = '0;
  logic [APB_DW-1:0]     prdata;
  logic                  pready;

  sync_req_t             req_q[$];
  result_t               status_q[$];
  sync_req_t             next_req;
  result_t               want;
  int                    err_cnt = 0;
  int                    cycle_cnt = 0;
  int                    send_idle_pct = 0;
  int                    recv_idle_pct = 0;
  logic                  hold_go = 1'b0;
  int                    hold_left = 0;

  // tracked monitor state and register copy
  phase_t                trk_phase = PH_LEARN;
  logic [NOW_W-1:0]      trk_stamp = '0;
  logic [PERIOD_W-1:0]   trk_period = '0;
  cfg_t                  live_cfg = '{match_window: MATCH_WINDOW_RST,
                                      period_min: PERIOD_MIN_RST,
                                      period_max: PERIOD_MAX_RST,
                                      timeout_margin: TIMEOUT_MARGIN_RST};

  sync_period_monitor_top u_top (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_req_type           (in_req_type),
    .in_now_us             (in_now_us),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_step_ok           (out_step_ok),
    .out_timeout_seen      (out_timeout_seen),
    .out_mon_state         (out_mon_state),
    .out_learned_period_us (out_learned_period_us),
    .psel                  (psel),
    .penable               (penable),
    .pwrite                (pwrite),
    .paddr                 (paddr),
    .pwdata                (pwdata),
    .prdata                (prdata),
    .pready                (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic result_t apply_request(input req_t req, input logic [NOW_W-1:0] now);
    result_t             r;
    logic [PERIOD_W-1:0] meas;
    logic [PERIOD_W-1:0] gap;
    logic [PERIOD_W-1:0] sum;
    logic [NOW_W-1:0]    deadline;
    logic                ok;
    logic                tmo;
    ok  = 1'b0;
    tmo = 1'b0;
    if (req == REQ_SYNC) begin
      ok = 1'b1;
      case (trk_phase)
        PH_LEARN: begin
          if (trk_stamp == '0) begin
            trk_stamp = now;
          end else begin
            meas      = PERIOD_W'(now - trk_stamp);
            gap       = meas - trk_period;
            trk_stamp = now;
            if (gap < PERIOD_W'(live_cfg.match_window)) begin
              sum        = trk_period + meas;
              trk_period = sum >> 1;
              if (trk_period >= PERIOD_W'(live_cfg.period_min) &&
                  trk_period <= PERIOD_W'(live_cfg.period_max)) begin
                trk_phase = PH_ACTIVE;
              end else begin
                ok = 1'b0;
              end
            end else begin
              trk_period = meas;
            end
          end
        end
        PH_ACTIVE: begin
          trk_stamp = now;
        end
        default: begin
          trk_phase  = PH_LEARN;
          trk_stamp  = '0;
          trk_period = '0;
        end
      endcase
    end else if (trk_phase == PH_ACTIVE) begin
      deadline = trk_stamp + NOW_W'(trk_period) + NOW_W'(live_cfg.timeout_margin);
      if (now > deadline) begin
        trk_phase = PH_TIMEOUT;
        tmo       = 1'b1;
      end
    end
    r.step_ok        = ok;
    r.timeout_seen   = tmo;
    r.mon_state      = trk_phase;
    r.learned_period = trk_period;
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        status_q.push_back(apply_request(req_t'(in_req_type), in_now_us));
      end
      if (!in_valid || in_ready) begin
        if (req_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_req = req_q.pop_front();
          in_valid    <= 1'b1;
          in_req_type <= next_req.req;
          in_now_us   <= next_req.now;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (hold_go) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    out_ready <= (hold_left == 0) && !hold_go && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t mismatch %s: expected %0h actual %0h", $time, name, exp_v, got_v);
      err_cnt++;
    end
  endtask

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (status_q.size() == 0) begin
        $display("%0t unexpected result beat: ok %0b tmo %0b state %0d period %0h",
                 $time, out_step_ok, out_timeout_seen, out_mon_state,
                 out_learned_period_us);
        err_cnt++;
      end else begin
        want = status_q.pop_front();
        check_field("step_ok", want.step_ok, out_step_ok);
        check_field("timeout_seen", want.timeout_seen, out_timeout_seen);
        check_field("mon_state", want.mon_state, out_mon_state);
        check_field("learned_period_us", want.learned_period, out_learned_period_us);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic queue_req(input req_t req, input logic [NOW_W-1:0] now);
    sync_req_t s;
    s.req = req;
    s.now = now;
    req_q.push_back(s);
  endtask

  task automatic cfg_write(input reg_idx_t idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'({idx, 2'b00});
    pwdata  <= {16'($urandom), val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_MATCH_WINDOW:   live_cfg.match_window   = val;
      REG_PERIOD_MIN:     live_cfg.period_min     = val;
      REG_PERIOD_MAX:     live_cfg.period_max     = val;
      REG_TIMEOUT_MARGIN: live_cfg.timeout_margin = val;
      default: ;
    endcase
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== APB_DW'(val)) begin
      $display("%0t mismatch readback reg %0d: expected %0h actual %0h",
               $time, idx, APB_DW'(val), prdata);
      err_cnt++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [PERIOD_W-1:0] pick_period();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return $urandom;
    if (r == 1) return $urandom_range(1, 50);
    if (live_cfg.period_min <= live_cfg.period_max)
      return $urandom_range(live_cfg.period_min, live_cfg.period_max);
    return $urandom_range(0, 65535);
  endfunction

  // a sync train with jitter inside the window, checks around the deadline,
  // and some stray beats
  task automatic add_sync_train(input int n);
    logic [NOW_W-1:0]    t;
    logic [PERIOD_W-1:0] p;
    int                  jit;
    int                  k;
    int                  r;
    p = pick_period();
    r = $urandom_range(0, 3);
    if (r == 0) t = $urandom_range(0, 3);
    else if (r == 1) t = 64'hFFFF_FFFF_FFFF_0000 | 64'($urandom_range(0, 65535));
    else t = {$urandom, $urandom};
    jit = (live_cfg.match_window > 16) ? 15 : int'(live_cfg.match_window) - 1;
    for (k = 0; k < n; k++) begin
      r = $urandom_range(0, 19);
      if (r < 12) begin
        t = t + NOW_W'(p) + NOW_W'($urandom_range(0, jit));
        queue_req(REQ_SYNC, t);
      end else if (r < 18) begin
        queue_req(REQ_CHECK, t + NOW_W'(p) + NOW_W'(live_cfg.timeout_margin) + 64'd10
                             - NOW_W'($urandom_range(0, 20)));
      end else if (r == 18) begin
        queue_req(REQ_CHECK, {$urandom, $urandom});
      end else begin
        queue_req(REQ_SYNC, {$urandom, $urandom});
      end
    end
  endtask

  task automatic add_random(input int n);
    int done;
    int len;
    done = 0;
    while (done < n) begin
      len = $urandom_range(6, 30);
      add_sync_train(len);
      done += len;
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (req_q.size() != 0 || in_valid || status_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    logic [NOW_W-1:0] t;
    int               lo;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 15;
    recv_idle_pct = 81;

    // learning, lock, timeout and restart with reset settings
    queue_req(REQ_CHECK, 64'd5);
    queue_req(REQ_SYNC, 64'd0);
    queue_req(REQ_SYNC, 64'd1000);
    queue_req(REQ_SYNC, 64'd2000);
    queue_req(REQ_SYNC, 64'd3005);
    queue_req(REQ_CHECK, 64'd4107);
    queue_req(REQ_SYNC, 64'd4000);
    queue_req(REQ_CHECK, 64'd5103);
    queue_req(REQ_CHECK, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_req(REQ_SYNC, 64'd6000);
    // stamp difference across the 64-bit wrap
    queue_req(REQ_SYNC, 64'hFFFF_FFFF_FFFF_FF00);
    queue_req(REQ_SYNC, 64'h300);
    queue_req(REQ_SYNC, 64'h706);
    // deadline sum wrapping past the top
    queue_req(REQ_SYNC, 64'hFFFF_FFFF_FFFF_FFF0);
    queue_req(REQ_CHECK, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_req(REQ_SYNC, 64'd7);
    // period sum overflow, then matching averages below the lower limit
    t = 64'd10;
    queue_req(REQ_SYNC, t);
    t = t + 64'hFFFF_FFF0;
    queue_req(REQ_SYNC, t);
    t = t + 64'hFFFF_FFF5;
    queue_req(REQ_SYNC, t);
    t = t + 64'd100;
    queue_req(REQ_SYNC, t);
    t = t + 64'd105;
    queue_req(REQ_SYNC, t);
    t = t + 64'h1_0000_0066;
    queue_req(REQ_SYNC, t);
    queue_req(REQ_CHECK, 64'd0);
    add_random(150);
    wait_drained();

    // exact match only, widest limits, no margin
    cfg_write(REG_MATCH_WINDOW, 16'd1);
    cfg_write(REG_PERIOD_MIN, 16'd0);
    cfg_write(REG_PERIOD_MAX, 16'hFFFF);
    cfg_write(REG_TIMEOUT_MARGIN, 16'd0);
    add_random(130);
    wait_drained();

    // crossed limits, widest window and margin
    send_idle_pct = 81;
    recv_idle_pct = 15;
    cfg_write(REG_MATCH_WINDOW, 16'hFFFF);
    cfg_write(REG_PERIOD_MIN, 16'hFFFF);
    cfg_write(REG_PERIOD_MAX, 16'd0);
    cfg_write(REG_TIMEOUT_MARGIN, 16'hFFFF);
    add_random(100);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    lo = $urandom_range(0, 60000);
    cfg_write(REG_MATCH_WINDOW, 16'($urandom_range(2, 500)));
    cfg_write(REG_PERIOD_MIN, 16'(lo));
    cfg_write(REG_PERIOD_MAX, 16'($urandom_range(lo, 65535)));
    cfg_write(REG_TIMEOUT_MARGIN, 16'($urandom_range(0, 65535)));
    @(posedge clk);
    hold_go <= 1'b1;
    @(posedge clk);
    hold_go <= 1'b0;
    add_random(170);
    wait_drained();

    repeat (10) @(posedge clk);
    if (status_q.size() != 0) begin
      $display("%0t %0d expected result beats never arrived", $time, status_q.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
hdl/spm_pkg.sv
hdl/spm_regs.sv
hdl/spm_step.sv
hdl/sync_period_monitor_top.sv
tb/testbench.sv
